// ===== hw/rtl/sffp_pkg.sv =====
`default_nettype none

package sffp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 9;
  localparam int unsigned KindW = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_FEATURE_WRITE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FEATURE_READ  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_DONE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_CONFIG  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SET_LEDS      = 3'd4;

  // event kinds
  localparam logic [KindW-1:0] EV_NONE  = 3'd0;
  localparam logic [KindW-1:0] EV_STORE = 3'd1;
  localparam logic [KindW-1:0] EV_READ  = 3'd2;
  localparam logic [KindW-1:0] EV_CMD   = 3'd3;
  localparam logic [KindW-1:0] EV_DONE  = 3'd4;

  localparam logic TGT_CONFIG = 1'b0;
  localparam logic TGT_LEDS   = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LEN  = 6'b000010,
    ST_READ = 6'b000100,
    ST_CMD  = 6'b001000,
    ST_OFS  = 6'b010000,
    ST_PAY  = 6'b100000
  } state_t;

  // one received byte with its code matches
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_write;
    logic             is_read;
    logic             is_done;
    logic             is_wcfg;
    logic             is_leds;
  } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sffp_front.sv =====
`default_nettype none

module sffp_front
  import sffp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]   cfg_data,
  input  wire logic [ByteW-1:0]   rx_byte,
  output item_t                   item
);

  logic [ByteW-1:0] code_feature_write;
  logic [ByteW-1:0] code_feature_read;
  logic [ByteW-1:0] code_frame_done;
  logic [ByteW-1:0] code_write_config;
  logic [ByteW-1:0] code_set_leds;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_feature_write <= 8'd1;
      code_feature_read  <= 8'd2;
      code_frame_done    <= 8'd3;
      code_write_config  <= 8'd4;
      code_set_leds      <= 8'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FEATURE_WRITE: code_feature_write <= cfg_data;
        CFG_FEATURE_READ:  code_feature_read  <= cfg_data;
        CFG_FRAME_DONE:    code_frame_done    <= cfg_data;
        CFG_WRITE_CONFIG:  code_write_config  <= cfg_data;
        CFG_SET_LEDS:      code_set_leds      <= cfg_data;
        default: ;
      endcase
    end
  end

  // codes may overlap, the parser applies the priority
  always_comb begin
    item.data     = rx_byte;
    item.is_write = (rx_byte == code_feature_write);
    item.is_read  = (rx_byte == code_feature_read);
    item.is_done  = (rx_byte == code_frame_done);
    item.is_wcfg  = (rx_byte == code_write_config);
    item.is_leds  = (rx_byte == code_set_leds);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sffp_queue.sv =====
`default_nettype none

module sffp_queue
  import sffp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  item_t     wr_item,
  output logic      full,
  output logic      rd_valid,
  input  wire logic rd_en,
  output item_t     rd_item
);

  item_t            mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == QCntW'(QDepth));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sffp_back.sv =====
`default_nettype none

module sffp_back
  import sffp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  item_t                 in_item,
  output logic                  in_take,
  output logic                  empty,
  input  wire logic             pop,
  output logic [KindW-1:0]      event_kind,
  output logic                  store_target,
  output logic [AddrW-1:0]      store_address,
  output logic [ByteW-1:0]      event_data
);

  state_t           state;
  state_t           state_next;
  logic [ByteW-1:0] remaining_count;
  logic [ByteW-1:0] remaining_count_next;
  logic [AddrW-1:0] write_offset;
  logic [AddrW-1:0] write_offset_next;
  logic             write_target;
  logic             write_target_next;

  logic             out_valid;
  logic [KindW-1:0] kind_next;
  logic             tgt_next;
  logic [AddrW-1:0] addr_next;
  logic [ByteW-1:0] data_next;
  logic [ByteW-1:0] cnt_dec;

  // result register frees up in the same cycle it is popped
  assign in_take = in_valid && (!out_valid || pop);
  assign empty   = !out_valid;
  assign cnt_dec = remaining_count - 1'b1;

  always_comb begin
    state_next           = state;
    remaining_count_next = remaining_count;
    write_offset_next    = write_offset;
    write_target_next    = write_target;
    kind_next            = EV_NONE;
    tgt_next             = TGT_CONFIG;
    addr_next            = '0;
    data_next            = '0;
    case (state)
      ST_IDLE: begin
        if (in_item.is_write) begin
          state_next = ST_LEN;
        end else if (in_item.is_read) begin
          state_next = ST_READ;
        end else if (in_item.is_done) begin
          kind_next = EV_DONE;
        end
      end
      ST_LEN: begin
        remaining_count_next = in_item.data;
        state_next           = ST_CMD;
      end
      ST_READ: begin
        kind_next  = EV_READ;
        data_next  = in_item.data;
        state_next = ST_IDLE;
      end
      ST_CMD: begin
        if (in_item.is_wcfg) begin
          write_target_next    = TGT_CONFIG;
          write_offset_next    = '0;
          remaining_count_next = cnt_dec;
          state_next           = ST_OFS;
        end else if (in_item.is_leds) begin
          write_target_next    = TGT_LEDS;
          write_offset_next    = '0;
          remaining_count_next = cnt_dec;
          state_next           = ST_PAY;
        end else begin
          kind_next  = EV_CMD;
          data_next  = in_item.data;
          state_next = ST_IDLE;
        end
      end
      ST_OFS: begin
        write_offset_next = write_offset + AddrW'(in_item.data);
        state_next        = ST_PAY;
      end
      ST_PAY: begin
        remaining_count_next = cnt_dec;
        kind_next            = EV_STORE;
        tgt_next             = write_target;
        addr_next            = write_offset;
        data_next            = in_item.data;
        write_offset_next    = write_offset + 1'b1;
        if (cnt_dec == '0) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      remaining_count <= '0;
      write_offset    <= '0;
      write_target    <= TGT_CONFIG;
      out_valid       <= 1'b0;
    end else begin
      if (in_take) begin
        state           <= state_next;
        remaining_count <= remaining_count_next;
        write_offset    <= write_offset_next;
        write_target    <= write_target_next;
        out_valid       <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      event_kind    <= kind_next;
      store_target  <= tgt_next;
      store_address <= addr_next;
      event_data    <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/serial_feature_frame_parser.sv =====
`default_nettype none

// channel   handshake               payload
// input     push / full             rx_byte
// result    empty / pop             event_kind, store_target, store_address, event_data
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one byte per cycle sustained while the result side keeps popping, one result
// per byte; each byte is registered in the queue and then in the result register.
// the byte is classified on entry, parked in a four-entry queue, and the
// parser takes it once the single result register is free or being popped.
// reset puts the parser in idle and the codes at their defaults; cfg_ready
// is always high.

module serial_feature_frame_parser
  import sffp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [ByteW-1:0]   rx_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic [KindW-1:0]        event_kind,
  output logic                    store_target,
  output logic [AddrW-1:0]        store_address,
  output logic [ByteW-1:0]        event_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]   cfg_data
);

  item_t front_item;
  item_t queue_item;
  logic  queue_valid;
  logic  queue_take;

  assign cfg_ready = 1'b1;

  sffp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .item      (front_item)
  );

  sffp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_item  (front_item),
    .full     (full),
    .rd_valid (queue_valid),
    .rd_en    (queue_take),
    .rd_item  (queue_item)
  );

  sffp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (queue_valid),
    .in_item       (queue_item),
    .in_take       (queue_take),
    .empty         (empty),
    .pop           (pop),
    .event_kind    (event_kind),
    .store_target  (store_target),
    .store_address (store_address),
    .event_data    (event_data)
  );

endmodule

`default_nettype wire
